// ----- src/seeded_color_data_term_defines.svh -----
// Assertion macros for the top block, which checks itself.
// Both macros sample on clk and are off while rst_n is low.
`ifndef SEEDED_COLOR_DATA_TERM_DEFINES_SVH
`define SEEDED_COLOR_DATA_TERM_DEFINES_SVH

// Same-cycle implication.
`define SCDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("scdt check failed");

// Next-cycle implication.
`define SCDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("scdt check failed");

`endif

// ----- src/scdt_pkg.sv -----
package scdt_pkg;

    // Clusters per table by default
    localparam int MAX_CLUSTERS_DEF = 64;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int SEED_W  = 2;
    localparam int CNT_W   = 7;
    localparam int NUM_CNT_W = CNT_W + 1;

    // Arithmetic widths
    localparam int D2_W    = 18;               // squared color distance
    localparam int FRAC_W  = 16;               // radicand scale for Q9.8
    localparam int RAD_W   = D2_W + FRAC_W;    // sqrt radicand
    localparam int DIST_W  = RAD_W / 2;        // Q9.8 distance
    localparam int ROOT_REM_W = DIST_W + 1;
    localparam int WGT_W   = 17;               // Q1.16 weight
    localparam int DEN_W   = DIST_W + 1;       // df + db
    localparam int NUM_W   = DEN_W + WGT_W;    // dividend
    localparam int STEP_W  = 5;                // holds DIST_W and WGT_W

    localparam logic [WGT_W-1:0] WGT_HALF = WGT_W'(32768);

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD_FORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_BACK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

    // Seed classes
    localparam logic [SEED_W-1:0] SEED_NONE = 2'd0;
    localparam logic [SEED_W-1:0] SEED_FORE = 2'd1;
    localparam logic [SEED_W-1:0] SEED_BACK = 2'd2;

    // Configuration register indexes
    localparam logic REG_FORE_COUNT = 1'b0;
    localparam logic REG_BACK_COUNT = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } scdt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_fore;
        logic load_back;
        logic scan;
        logic root_start;
        logic div_start;
        logic publish;
    } scdt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic root_busy;
        logic div_busy;
    } scdt_stat_t;

endpackage

// ----- src/seeded_color_data_term.sv -----
// Seeded color data term. Load words (mode 0/1) write one palette entry;
// busy stays low, so the block stays free, and they give no result.
// A query (mode 2) with a foreground or background seed goes straight to the
// finish state and gives its result from there. An unmarked query scans both
// palettes together, one entry per cycle through a single read port on each
// memory, over the larger of the two clamped counts, then runs two 17-step
// square roots and two 17-step divisions before its result word appears.
// busy stays high until the result is out. The result is valid only in the
// single cycle that done is high; the receiver cannot stall and must take it
// then. Counts are written through the cfg port, which is always ready; the
// user must write them only while busy is low, as the block does not enforce it.
`include "seeded_color_data_term_defines.svh"

module seeded_color_data_term
    import scdt_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [MODE_W-1:0]  mode,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [CHAN_W-1:0]  red,
    input  logic [CHAN_W-1:0]  green,
    input  logic [CHAN_W-1:0]  blue,
    input  logic [SEED_W-1:0]  seed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [CNT_W-1:0]   cfg_data,
    output logic               done,
    output logic [WGT_W-1:0]   source_weight,
    output logic [WGT_W-1:0]   sink_weight,
    output logic               source_infinite,
    output logic               sink_infinite,
    output logic [DIST_W-1:0]  fore_distance,
    output logic [DIST_W-1:0]  back_distance
);

    scdt_cmd_t  cmd;
    scdt_stat_t stat;

    assign cfg_ready = 1'b1;

    scdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .seed  (seed),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    scdt_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .slot            (slot),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .seed            (seed),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .source_weight   (source_weight),
        .sink_weight     (sink_weight),
        .source_infinite (source_infinite),
        .sink_infinite   (sink_infinite),
        .fore_distance   (fore_distance),
        .back_distance   (back_distance)
    );

    // Result strobe is a single-cycle pulse and the block is free when it fires
    `SCDT_ASSERT_NXT(a_done_single, done, !done)
    `SCDT_ASSERT_IMP(a_done_idle, done, !busy)

    // Loads leave the block free at the next edge
    `SCDT_ASSERT_NXT(a_load_quick, start && !busy && (mode != MODE_QUERY), !busy)

    // Foreground seed answers with sink_infinite set and source_infinite clear
    `SCDT_ASSERT_IMP(a_fore_seed, start && !busy && (mode == MODE_QUERY) && (seed == SEED_FORE), ##2 (done && sink_infinite && !source_infinite))

endmodule

// ----- src/scdt_sqrt.sv -----
module scdt_sqrt
    import scdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  operand,
    output logic [DIST_W-1:0] root,
    output logic              busy
);

    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_REM_W-1:0]   rem_reg;
    logic [DIST_W-1:0]       root_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [ROOT_REM_W+1:0]   rem_shift;
    logic [ROOT_REM_W+1:0]   trial;
    logic                    fits;

    // One result bit per step: bring in two radicand bits, try (root*4+1)
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = (ROOT_REM_W+2)'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(DIST_W);
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? ROOT_REM_W'(rem_shift - trial) : ROOT_REM_W'(rem_shift);
            root_reg <= {root_reg[DIST_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign busy = (step_reg != '0);

endmodule

// ----- src/scdt_div.sv -----
module scdt_div
    import scdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic [WGT_W-1:0]  quotient,
    output logic              busy
);

    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [WGT_W-1:0]   low_reg;
    logic [WGT_W-1:0]   quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DEN_W:0]     rem_shift;
    logic               fits;

    // Restoring division, one quotient bit per step; the upper dividend
    // bits are below the divisor since the quotient fits WGT_W bits
    always_comb
    begin
        rem_shift = {rem_reg, low_reg[WGT_W-1]};
        fits      = (rem_shift >= {1'b0, den_reg});
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(WGT_W);
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[NUM_W-1:WGT_W];
            low_reg <= dividend[WGT_W-1:0];
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= fits ? DEN_W'(rem_shift - {1'b0, den_reg}) : DEN_W'(rem_shift);
            low_reg <= {low_reg[WGT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[WGT_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign busy     = (step_reg != '0);

endmodule

// ----- src/scdt_datapath.sv -----
module scdt_datapath
    import scdt_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  scdt_cmd_t          cmd,
    output scdt_stat_t         stat,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [CHAN_W-1:0]  red,
    input  logic [CHAN_W-1:0]  green,
    input  logic [CHAN_W-1:0]  blue,
    input  logic [SEED_W-1:0]  seed,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [CNT_W-1:0]   cfg_data,
    output logic               done,
    output logic [WGT_W-1:0]   source_weight,
    output logic [WGT_W-1:0]   sink_weight,
    output logic               source_infinite,
    output logic               sink_infinite,
    output logic [DIST_W-1:0]  fore_distance,
    output logic [DIST_W-1:0]  back_distance
);

    localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam logic [NUM_CNT_W-1:0] MAX_N = NUM_CNT_W'(MAX_CLUSTERS);

    // Squared distance between two packed colors
    function automatic logic [D2_W-1:0] color_d2(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
        logic [CHAN_W-1:0]   ad;
        logic [D2_W-1:0]     acc;
        logic [CHAN_W-1:0]   ca;
        logic [CHAN_W-1:0]   cb;
        acc = '0;
        for (int c = 0; c < 3; c++)
        begin
            ca  = a[c*CHAN_W +: CHAN_W];
            cb  = b[c*CHAN_W +: CHAN_W];
            ad  = (ca > cb) ? (ca - cb) : (cb - ca);
            acc = acc + D2_W'(ad * ad);
        end
        return acc;
    endfunction

    logic [COLOR_W-1:0]    fore_mem [MAX_CLUSTERS];
    logic [COLOR_W-1:0]    back_mem [MAX_CLUSTERS];

    logic [CNT_W-1:0]      fore_count_reg;
    logic [CNT_W-1:0]      back_count_reg;
    logic [NUM_CNT_W-1:0]  fore_n;
    logic [NUM_CNT_W-1:0]  back_n;
    logic [NUM_CNT_W-1:0]  scan_n;
    logic [NUM_CNT_W-1:0]  idx_ext;
    logic [NUM_CNT_W-1:0]  slot_ext;
    logic [AW+SLOT_W-1:0]  slot_wide;
    logic [AW-1:0]         waddr;
    logic                  slot_ok;

    logic [CHAN_W-1:0]     red_reg;
    logic [CHAN_W-1:0]     green_reg;
    logic [CHAN_W-1:0]     blue_reg;
    logic [SEED_W-1:0]     seed_reg;
    logic [COLOR_W-1:0]    query_color;

    logic [AW-1:0]         scan_idx_reg;
    logic [COLOR_W-1:0]    fore_rd_reg;
    logic [COLOR_W-1:0]    back_rd_reg;
    logic                  fore_v1_reg;
    logic                  back_v1_reg;
    logic                  fore_v2_reg;
    logic                  back_v2_reg;
    logic [D2_W-1:0]       fore_d2_reg;
    logic [D2_W-1:0]       back_d2_reg;
    logic [D2_W-1:0]       fore_best_reg;
    logic [D2_W-1:0]       back_best_reg;

    logic [DIST_W-1:0]     fore_root;
    logic [DIST_W-1:0]     back_root;
    logic                  fore_root_busy;
    logic                  back_root_busy;
    logic [DEN_W-1:0]      dist_sum;
    logic [NUM_W-1:0]      fore_num;
    logic [NUM_W-1:0]      back_num;
    logic [WGT_W-1:0]      fore_quo;
    logic [WGT_W-1:0]      back_quo;
    logic                  fore_div_busy;
    logic                  back_div_busy;

    logic                  done_reg;
    logic [WGT_W-1:0]      src_w_reg;
    logic [WGT_W-1:0]      snk_w_reg;
    logic                  src_inf_reg;
    logic                  snk_inf_reg;
    logic [DIST_W-1:0]     fore_dist_reg;
    logic [DIST_W-1:0]     back_dist_reg;

    // Count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_count_reg <= CNT_W'(1);
            back_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FORE_COUNT)
            begin
                fore_count_reg <= cfg_data;
            end
            else
            begin
                back_count_reg <= cfg_data;
            end
        end
    end

    // Clamped counts and scan length
    always_comb
    begin
        if (fore_count_reg == '0)
            fore_n = NUM_CNT_W'(1);
        else if ({1'b0, fore_count_reg} > MAX_N)
            fore_n = MAX_N;
        else
            fore_n = {1'b0, fore_count_reg};

        if (back_count_reg == '0)
            back_n = NUM_CNT_W'(1);
        else if ({1'b0, back_count_reg} > MAX_N)
            back_n = MAX_N;
        else
            back_n = {1'b0, back_count_reg};

        scan_n  = (fore_n > back_n) ? fore_n : back_n;
        idx_ext = NUM_CNT_W'(scan_idx_reg);
    end

    // Load address
    always_comb
    begin
        slot_ext  = NUM_CNT_W'(slot);
        slot_ok   = (slot_ext < MAX_N);
        slot_wide = (AW+SLOT_W)'(slot);
        waddr     = slot_wide[AW-1:0];
    end

    // Palette memories: one write, one registered scan read
    always_ff @(posedge clk)
    begin
        if (cmd.load_fore && slot_ok)
        begin
            fore_mem[waddr] <= {red, green, blue};
        end
        if (cmd.scan)
        begin
            fore_rd_reg <= fore_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_back && slot_ok)
        begin
            back_mem[waddr] <= {red, green, blue};
        end
        if (cmd.scan)
        begin
            back_rd_reg <= back_mem[scan_idx_reg];
        end
    end

    // Query word capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            seed_reg  <= seed;
        end
    end

    assign query_color = {red_reg, green_reg, blue_reg};

    // Scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.capture)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    assign stat.scan_last = (idx_ext == scan_n - 1'b1);

    // Scan pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_v1_reg <= 1'b0;
            back_v1_reg <= 1'b0;
            fore_v2_reg <= 1'b0;
            back_v2_reg <= 1'b0;
        end
        else
        begin
            fore_v1_reg <= cmd.scan && (idx_ext < fore_n);
            back_v1_reg <= cmd.scan && (idx_ext < back_n);
            fore_v2_reg <= fore_v1_reg;
            back_v2_reg <= back_v1_reg;
        end
    end

    // Squared distance stage and running minimum
    always_ff @(posedge clk)
    begin
        fore_d2_reg <= color_d2(query_color, fore_rd_reg);
        back_d2_reg <= color_d2(query_color, back_rd_reg);
        if (cmd.capture)
        begin
            fore_best_reg <= '1;
            back_best_reg <= '1;
        end
        else
        begin
            if (fore_v2_reg && (fore_d2_reg < fore_best_reg))
                fore_best_reg <= fore_d2_reg;
            if (back_v2_reg && (back_d2_reg < back_best_reg))
                back_best_reg <= back_d2_reg;
        end
    end

    // Square roots of the minima, Q9.8
    scdt_sqrt u_fore_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.root_start),
        .operand ({fore_best_reg, FRAC_W'(0)}),
        .root    (fore_root),
        .busy    (fore_root_busy)
    );

    scdt_sqrt u_back_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.root_start),
        .operand ({back_best_reg, FRAC_W'(0)}),
        .root    (back_root),
        .busy    (back_root_busy)
    );

    assign stat.root_busy = fore_root_busy || back_root_busy;

    // Rounded dividends x*2^16 + s/2
    always_comb
    begin
        dist_sum = {1'b0, fore_root} + {1'b0, back_root};
        fore_num = NUM_W'({fore_root, FRAC_W'(0)}) + NUM_W'(dist_sum[DEN_W-1:1]);
        back_num = NUM_W'({back_root, FRAC_W'(0)}) + NUM_W'(dist_sum[DEN_W-1:1]);
    end

    scdt_div u_fore_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (fore_num),
        .divisor  (dist_sum),
        .quotient (fore_quo),
        .busy     (fore_div_busy)
    );

    scdt_div u_back_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (back_num),
        .divisor  (dist_sum),
        .quotient (back_quo),
        .busy     (back_div_busy)
    );

    assign stat.div_busy = fore_div_busy || back_div_busy;

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.publish;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            case (seed_reg)
                SEED_FORE:
                begin
                    src_w_reg     <= '0;
                    snk_w_reg     <= '0;
                    src_inf_reg   <= 1'b0;
                    snk_inf_reg   <= 1'b1;
                    fore_dist_reg <= '0;
                    back_dist_reg <= '0;
                end
                SEED_BACK:
                begin
                    src_w_reg     <= '0;
                    snk_w_reg     <= '0;
                    src_inf_reg   <= 1'b1;
                    snk_inf_reg   <= 1'b0;
                    fore_dist_reg <= '0;
                    back_dist_reg <= '0;
                end
                default:
                begin
                    // both distances zero gives one half each
                    src_w_reg     <= (dist_sum == '0) ? WGT_HALF : fore_quo;
                    snk_w_reg     <= (dist_sum == '0) ? WGT_HALF : back_quo;
                    src_inf_reg   <= 1'b0;
                    snk_inf_reg   <= 1'b0;
                    fore_dist_reg <= fore_root;
                    back_dist_reg <= back_root;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign source_weight   = src_w_reg;
    assign sink_weight     = snk_w_reg;
    assign source_infinite = src_inf_reg;
    assign sink_infinite   = snk_inf_reg;
    assign fore_distance   = fore_dist_reg;
    assign back_distance   = back_dist_reg;

endmodule

// ----- src/scdt_ctrl.sv -----
module scdt_ctrl
    import scdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MODE_W-1:0]  mode,
    input  logic [SEED_W-1:0]  seed,
    input  scdt_stat_t         stat,
    output scdt_cmd_t          cmd,
    output logic               busy
);

    scdt_state_t state_reg;
    scdt_state_t state_next;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (mode == MODE_QUERY))
                begin
                    if ((seed == SEED_FORE) || (seed == SEED_BACK))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                    state_next = ST_DRAIN_A;
            end
            ST_DRAIN_A:   state_next = ST_DRAIN_B;
            ST_DRAIN_B:   state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (!stat.root_busy)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd            = '0;
        cmd.capture    = accept;
        cmd.load_fore  = accept && (mode == MODE_LOAD_FORE);
        cmd.load_back  = accept && (mode == MODE_LOAD_BACK);
        cmd.scan       = (state_reg == ST_SCAN);
        cmd.root_start = (state_reg == ST_ROOT_GO);
        cmd.div_start  = (state_reg == ST_DIV_GO);
        cmd.publish    = (state_reg == ST_FINISH);
        busy           = (state_reg != ST_IDLE);
    end

endmodule
